### hdl/rptt_pkg.sv
// ----------------------------------------------------------------------------
// rptt_pkg: shared types for the relay pulse train timer
// Request and event payloads, command codes and sequence phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package rptt_pkg;

	// Command codes carried by a request
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_SINGLE = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_SEQ    = 2'd3
	} cmd_t;

	// Sequence channel phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ON   = 3'b010,
		PH_GAP  = 3'b100
	} phase_t;

	// Fixed field widths
	localparam int RelayW = 4;
	localparam int TimeW  = 32;
	localparam int IndexW = 4;
	localparam int CountW = 5;

	// Request payload
	typedef struct packed {
		cmd_t              cmd;
		logic [RelayW-1:0] relay_id;
		logic [TimeW-1:0]  pulse_ms;
		logic [TimeW-1:0]  gap_ms;
		logic [IndexW-1:0] step_index;
		logic [CountW-1:0] step_count;
	} req_t;

	// Event payload
	typedef struct packed {
		logic              single_press;
		logic              single_release;
		logic [RelayW-1:0] single_relay;
		logic              seq_press;
		logic              seq_release;
		logic [RelayW-1:0] seq_relay;
		logic              single_busy;
		logic              seq_busy;
	} evt_t;

endpackage

`default_nettype wire

### hdl/rptt_ram.sv
// ----------------------------------------------------------------------------
// rptt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module rptt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/rptt_timer.sv
// ----------------------------------------------------------------------------
// rptt_timer: tick counter, channel state and step table
// Applies one accepted request per cycle and forms its event. The step table
// entry needed at the next sequence transition is prefetched from RAM,
// addressed from the next state, with a bypass for a write to the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rptt_timer
	import rptt_pkg::*;
#(
	parameter int MAX_STEPS   = 16,
	parameter int RELAY_COUNT = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire req_t req,
	output evt_t      rsp
);

	localparam int IdxW = $clog2(MAX_STEPS);
	localparam int ExtW = (IdxW > 6) ? IdxW : 6;
	localparam int WordW = 2 * TimeW;
	localparam logic [6:0] StepLim  = 7'(MAX_STEPS);
	localparam logic [6:0] RelayLim = 7'(RELAY_COUNT);

	// Registered state
	logic [TimeW-1:0]  tick_q, tick_d;
	logic              single_on_q, single_on_d;
	logic [RelayW-1:0] single_ch_q, single_ch_d;
	logic [TimeW-1:0]  single_end_q, single_end_d;
	logic              seq_on_q, seq_on_d;
	logic [RelayW-1:0] seq_ch_q, seq_ch_d;
	phase_t            phase_q, phase_d;
	logic [CountW-1:0] pos_q, pos_d;
	logic [CountW-1:0] len_q, len_d;
	logic [TimeW-1:0]  deadline_q, deadline_d;

	// Table storage and prefetch
	logic [MAX_STEPS-1:0] valid_q;
	logic                 rd_valid_q;
	logic                 byp_hit_q;
	logic [WordW-1:0]     byp_q;
	logic [WordW-1:0]     rdata;
	logic [WordW-1:0]     word_eff;
	logic [TimeW-1:0]     tbl_dur;
	logic                 we;
	logic [IdxW-1:0]      waddr, raddr;
	logic [ExtW-1:0]      wr_ext, rd_ext;
	logic [5:0]           rd_pos;
	logic [WordW-1:0]     wdata;

	// Request decode helpers
	logic [TimeW-1:0]  tick_inc;
	logic [TimeW-1:0]  single_diff, seq_diff;
	logic              relay_ok;
	logic [CountW-1:0] len_sat;
	logic [CountW-1:0] pos_inc;
	logic              s_press, s_rel, q_press, q_rel;

	rptt_ram #(
		.WIDTH (WordW),
		.DEPTH (MAX_STEPS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Prefetched entry: a same-cycle write wins, never-written entries read zero
	always_comb begin
		if (byp_hit_q) begin
			word_eff = byp_q;
		end else if (rd_valid_q) begin
			word_eff = rdata;
		end else begin
			word_eff = '0;
		end
		// on phase waits for the off time, otherwise the next on time is due
		tbl_dur = (phase_q == PH_ON) ? word_eff[TimeW-1:0] : word_eff[WordW-1:TimeW];
	end

	assign tick_inc    = tick_q + 1'b1;
	assign single_diff = tick_inc - single_end_q;
	assign seq_diff    = tick_inc - deadline_q;
	assign relay_ok    = 7'(req.relay_id) < RelayLim;
	assign len_sat     = (7'(req.step_count) > StepLim) ? 5'(StepLim) : req.step_count;
	assign pos_inc     = pos_q + 1'b1;

	// Table write port
	assign wr_ext = ExtW'(req.step_index);
	assign waddr  = wr_ext[IdxW-1:0];
	assign wdata  = {req.pulse_ms, req.gap_ms};

	// Next state
	always_comb begin
		tick_d       = tick_q;
		single_on_d  = single_on_q;
		single_ch_d  = single_ch_q;
		single_end_d = single_end_q;
		seq_on_d     = seq_on_q;
		seq_ch_d     = seq_ch_q;
		phase_d      = phase_q;
		pos_d        = pos_q;
		len_d        = len_q;
		deadline_d   = deadline_q;
		we           = 1'b0;
		s_press      = 1'b0;
		s_rel        = 1'b0;
		q_press      = 1'b0;
		q_rel        = 1'b0;
		if (accept) begin
			unique case (req.cmd)
				CMD_TICK: begin
					tick_d = tick_inc;
					if (single_on_q && !single_diff[TimeW-1]) begin
						s_rel       = 1'b1;
						single_on_d = 1'b0;
					end
					if (seq_on_q && !seq_diff[TimeW-1]) begin
						unique case (phase_q)
							PH_ON: begin
								q_rel = 1'b1;
								if ({1'b0, pos_inc} >= {1'b0, len_q} || pos_inc == '0) begin
									seq_on_d = 1'b0;
									phase_d  = PH_IDLE;
								end else begin
									phase_d    = PH_GAP;
									deadline_d = tick_inc + tbl_dur;
								end
							end
							PH_GAP: begin
								pos_d = pos_inc;
								if (pos_inc >= len_q) begin
									seq_on_d = 1'b0;
									phase_d  = PH_IDLE;
								end else begin
									q_press    = 1'b1;
									phase_d    = PH_ON;
									deadline_d = tick_inc + tbl_dur;
								end
							end
							default: begin
							end
						endcase
					end
				end
				CMD_SINGLE: begin
					if (!single_on_q && relay_ok) begin
						single_on_d  = 1'b1;
						single_ch_d  = req.relay_id;
						single_end_d = tick_q + req.pulse_ms;
						s_press      = 1'b1;
					end
				end
				CMD_WRITE: begin
					we = 7'(req.step_index) < StepLim;
				end
				CMD_SEQ: begin
					if (!seq_on_q && relay_ok && req.step_count != '0) begin
						seq_on_d   = 1'b1;
						seq_ch_d   = req.relay_id;
						len_d      = len_sat;
						pos_d      = '0;
						phase_d    = PH_ON;
						deadline_d = tick_q + tbl_dur;
						q_press    = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Prefetch address: entry due at the next transition of the next state
	always_comb begin
		unique case (phase_d)
			PH_ON:   rd_pos = {1'b0, pos_d};
			PH_GAP:  rd_pos = {1'b0, pos_d} + 6'd1;
			default: rd_pos = '0;
		endcase
		rd_ext = ExtW'(rd_pos);
		raddr  = rd_ext[IdxW-1:0];
	end

	// Event for this request
	always_comb begin
		rsp.single_press   = s_press;
		rsp.single_release = s_rel;
		rsp.single_relay   = single_ch_d;
		rsp.seq_press      = q_press;
		rsp.seq_release    = q_rel;
		rsp.seq_relay      = seq_ch_d;
		rsp.single_busy    = single_on_d;
		rsp.seq_busy       = seq_on_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			single_on_q  <= 1'b0;
			single_ch_q  <= '0;
			single_end_q <= '0;
			seq_on_q     <= 1'b0;
			seq_ch_q     <= '0;
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			len_q        <= '0;
			deadline_q   <= '0;
			valid_q      <= '0;
			rd_valid_q   <= 1'b0;
			byp_hit_q    <= 1'b0;
		end else begin
			tick_q       <= tick_d;
			single_on_q  <= single_on_d;
			single_ch_q  <= single_ch_d;
			single_end_q <= single_end_d;
			seq_on_q     <= seq_on_d;
			seq_ch_q     <= seq_ch_d;
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			len_q        <= len_d;
			deadline_q   <= deadline_d;
			rd_valid_q   <= valid_q[raddr];
			byp_hit_q    <= we && (waddr == raddr);
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// Bypass data
	always_ff @(posedge clk) begin
		byp_q <= wdata;
	end

endmodule

`default_nettype wire

### hdl/rptt_outq.sv
// ----------------------------------------------------------------------------
// rptt_outq: two-entry event buffer
// Output register plus skid register, so a request can be taken while the
// previous event is still waiting at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rptt_outq
	import rptt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire evt_t push_data,
	output logic      space,
	output logic      evt_valid,
	input  wire logic evt_ready,
	output evt_t      evt
);

	logic out_valid_q, skid_valid_q;
	evt_t out_q, skid_q;
	logic pop;

	assign pop       = out_valid_q && evt_ready;
	assign space     = !skid_valid_q;
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (pop && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (pop) begin
				out_valid_q <= push;
			end else if (push && out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else if (push) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		priority if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

### hdl/relay_pulse_train_timer_core.sv
// ----------------------------------------------------------------------------
// relay_pulse_train_timer_core: millisecond relay pulse and sequence timer
// Top level: request channel, timer state with step table, event buffer.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the event buffer has space and
// returns exactly one event per request, in the cycle after acceptance if
// the event channel is free. Ticks, pulse starts, step writes and sequence
// starts never stall: the step table is a RAM with registered read data and
// the entry for the next sequence transition is read ahead, with a bypass
// for a step write to that same entry. The table needs no clearing pass
// after reset; per-entry valid bits make unwritten steps read as zero. A
// two-entry event buffer keeps requests flowing while one event waits.
`default_nettype none

module relay_pulse_train_timer_core
	import rptt_pkg::*;
#(
	parameter int MAX_STEPS   = 16,
	parameter int RELAY_COUNT = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire req_t cmd_req,
	output logic      evt_valid,
	input  wire logic evt_ready,
	output evt_t      evt
);

	logic accept;
	evt_t rsp;
	logic space;

	assign cmd_ready = space;
	assign accept    = cmd_valid && space;

	rptt_timer #(
		.MAX_STEPS   (MAX_STEPS),
		.RELAY_COUNT (RELAY_COUNT)
	) u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (cmd_req),
		.rsp    (rsp)
	);

	rptt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (rsp),
		.space     (space),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

`ifndef SYNTHESIS
	// every accepted request leaves an event waiting
	a_evt_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> evt_valid)
		else $error("no event after accepted request");

	// only a tick can release a relay
	a_release_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_req.cmd != CMD_TICK |-> !rsp.single_release && !rsp.seq_release)
		else $error("relay released by a non-tick request");

	// a press leaves its channel busy
	a_press_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (rsp.single_press || rsp.seq_press) |->
		(!rsp.single_press || rsp.single_busy) && (!rsp.seq_press || rsp.seq_busy))
		else $error("press without busy channel");
`endif

endmodule

`default_nettype wire

### tb/tb_relay_pulse_train_timer_core.sv
// ----------------------------------------------------------------------------
// tb_relay_pulse_train_timer_core: self-checking bench for the relay timer
// Feeds ticks, pulse starts, step writes and sequence starts through the
// request channel. A local timer model predicts one event per request. Every
// event that comes back is checked field by field, in order. The run covers
// four sender/receiver idling profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_relay_pulse_train_timer_core;
	import rptt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS      = 16;
	localparam int RELAYS     = 16;
	localparam int PHASE_REQS = 300;
	localparam int STUCK_MAX  = 5000;
	localparam int DRAIN_WAIT = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	req_t cmd_req   = '0;
	logic evt_valid;
	logic evt_ready = 1'b0;
	evt_t evt;

	req_t queued_reqs[$];
	evt_t predicted_evts[$];
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   errors         = 0;
	int   stuck_cycles   = 0;

	// Timer model state
	logic [31:0] tick_now;
	logic        single_active;
	logic [3:0]  single_relay_q;
	logic [31:0] single_deadline;
	logic        seq_active;
	logic [3:0]  seq_relay_q;
	phase_t      seq_ph;
	int          seq_pos;
	int          seq_len;
	logic [31:0] seq_due;
	logic [31:0] on_ms[STEPS];
	logic [31:0] off_ms[STEPS];

	relay_pulse_train_timer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_req  (cmd_req),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt      (evt)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Wrap-safe compare: reached when (now - deadline) is non-negative
	function automatic logic deadline_met(logic [31:0] deadline);
		logic [31:0] diff;
		diff = tick_now - deadline;
		return !diff[31];
	endfunction

	// Advance the timer model by one request and build the event it causes
	task automatic step_timer(input req_t r, output evt_t e);
		int cnt;
		e = '0;
		cnt = int'(r.step_count);
		case (r.cmd)
		CMD_TICK: begin
			tick_now = tick_now + 32'd1;
			if (single_active && deadline_met(single_deadline)) begin
				e.single_release = 1'b1;
				single_active = 1'b0;
			end
			if (seq_active && deadline_met(seq_due)) begin
				if (seq_ph == PH_ON) begin
					e.seq_release = 1'b1;
					if (seq_pos + 1 >= seq_len) begin
						seq_active = 1'b0;
						seq_ph = PH_IDLE;
					end else begin
						seq_ph = PH_GAP;
						seq_due = tick_now + off_ms[seq_pos];
					end
				end else if (seq_ph == PH_GAP) begin
					seq_pos = seq_pos + 1;
					if (seq_pos >= seq_len) begin
						seq_active = 1'b0;
						seq_ph = PH_IDLE;
					end else begin
						e.seq_press = 1'b1;
						seq_ph = PH_ON;
						seq_due = tick_now + on_ms[seq_pos];
					end
				end
			end
		end
		CMD_SINGLE: begin
			if (!single_active && int'(r.relay_id) < RELAYS) begin
				single_active = 1'b1;
				single_relay_q = r.relay_id;
				single_deadline = tick_now + r.pulse_ms;
				e.single_press = 1'b1;
			end
		end
		CMD_WRITE: begin
			if (int'(r.step_index) < STEPS) begin
				on_ms[r.step_index] = r.pulse_ms;
				off_ms[r.step_index] = r.gap_ms;
			end
		end
		default: begin
			if (!seq_active && int'(r.relay_id) < RELAYS && cnt != 0) begin
				seq_active = 1'b1;
				seq_relay_q = r.relay_id;
				seq_len = (cnt > STEPS) ? STEPS : cnt;
				seq_pos = 0;
				seq_ph = PH_ON;
				seq_due = tick_now + on_ms[0];
				e.seq_press = 1'b1;
			end
		end
		endcase
		e.single_relay = single_relay_q;
		e.seq_relay = seq_relay_q;
		e.single_busy = single_active;
		e.seq_busy = seq_active;
	endtask

	function automatic req_t make_req(cmd_t c, logic [3:0] relay, logic [31:0] pulse,
			logic [31:0] gap, logic [3:0] idx, logic [4:0] cnt);
		req_t r;
		r.cmd = c;
		r.relay_id = relay;
		r.pulse_ms = pulse;
		r.gap_ms = gap;
		r.step_index = idx;
		r.step_count = cnt;
		return r;
	endfunction

	// Mostly short durations; sometimes a huge one that lands in the past
	function automatic logic [31:0] pick_ms();
		logic [31:0] v;
		if ($urandom_range(99) < 85)
			return 32'($urandom_range(6));
		v = {1'b1, 31'($urandom())};
		// exactly half the range away would not yet count as reached
		if (v == 32'h8000_0000)
			v = '1;
		return v;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int pick;
		r = make_req(CMD_TICK, 4'($urandom()), $urandom(), $urandom(),
			4'($urandom()), 5'($urandom()));
		pick = $urandom_range(99);
		if (pick < 55) begin
			r.cmd = CMD_TICK;
		end else if (pick < 67) begin
			r.cmd = CMD_SINGLE;
			r.pulse_ms = pick_ms();
		end else if (pick < 82) begin
			r.cmd = CMD_WRITE;
			r.pulse_ms = pick_ms();
			r.gap_ms = pick_ms();
		end else begin
			r.cmd = CMD_SEQ;
			pick = $urandom_range(99);
			if (pick < 80)
				r.step_count = 5'($urandom_range(1, 5));
			else if (pick < 90)
				r.step_count = '0;
			else
				r.step_count = 5'($urandom_range(6, 31));
		end
		return r;
	endfunction

	task automatic report_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
			errors++;
		end
	endtask

	task automatic wait_drained();
		while (queued_reqs.size() != 0 || predicted_evts.size() != 0 || cmd_valid)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Request driver
	always @(posedge clk) begin
		evt_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_ready) begin
			if (queued_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd_req <= queued_reqs.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Monitor: predict on request acceptance, check each event, watchdog
	always @(posedge clk) begin
		evt_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				step_timer(cmd_req, want);
				predicted_evts.push_back(want);
			end
			if (evt_valid && evt_ready) begin
				if (predicted_evts.size() == 0) begin
					$display("%0t: unexpected event: expected none, actual %h", $time, evt);
					errors++;
				end else begin
					want = predicted_evts.pop_front();
					report_field("single_press", 32'(want.single_press),
						32'(evt.single_press));
					report_field("single_release", 32'(want.single_release),
						32'(evt.single_release));
					report_field("single_relay", 32'(want.single_relay),
						32'(evt.single_relay));
					report_field("seq_press", 32'(want.seq_press), 32'(evt.seq_press));
					report_field("seq_release", 32'(want.seq_release),
						32'(evt.seq_release));
					report_field("seq_relay", 32'(want.seq_relay), 32'(evt.seq_relay));
					report_field("single_busy", 32'(want.single_busy),
						32'(evt.single_busy));
					report_field("seq_busy", 32'(want.seq_busy), 32'(evt.seq_busy));
				end
			end
			if ((cmd_valid && cmd_ready) || (evt_valid && evt_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_MAX) begin
				$display("%0t: watchdog: no request or event accepted", $time);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Stimulus and run control
	initial begin
		int ph;
		int n;
		tick_now = '0;
		single_active = 1'b0;
		single_relay_q = '0;
		single_deadline = '0;
		seq_active = 1'b0;
		seq_relay_q = '0;
		seq_ph = PH_IDLE;
		seq_pos = 0;
		seq_len = 0;
		seq_due = '0;
		for (n = 0; n < STEPS; n++) begin
			on_ms[n] = '0;
			off_ms[n] = '0;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: ignored starts, zero and extreme durations, saturation
		queued_reqs.push_back(make_req(CMD_TICK, 4'hA, '1, '1, 4'hF, 5'h1F));
		queued_reqs.push_back(make_req(CMD_SINGLE, 4'h0, 32'd0, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_SINGLE, 4'h5, 32'd7, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_TICK, '0, '0, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_SEQ, 4'h9, 32'd3, '0, '0, 5'd0));
		// untouched table: every step lasts zero ticks
		queued_reqs.push_back(make_req(CMD_SEQ, 4'hF, '0, '0, '0, 5'd2));
		repeat (3) queued_reqs.push_back(make_req(CMD_TICK, '0, '0, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_WRITE, '0, 32'd2, '1, 4'd0, '0));
		queued_reqs.push_back(make_req(CMD_WRITE, '0, '1, 32'd1, 4'd15, '0));
		queued_reqs.push_back(make_req(CMD_WRITE, '0, 32'd0, 32'd0, 4'd1, '0));
		// step count above the table depth saturates
		queued_reqs.push_back(make_req(CMD_SEQ, 4'h0, '0, '0, '0, 5'd31));
		// shares relay 0 with the running sequence
		queued_reqs.push_back(make_req(CMD_SINGLE, 4'h0, '1, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_SEQ, 4'h3, '0, '0, '0, 5'd1));
		queued_reqs.push_back(make_req(CMD_WRITE, '0, 32'd1, 32'd2, 4'd1, '0));
		repeat (6) queued_reqs.push_back(make_req(CMD_TICK, '0, '0, '0, '0, '0));
		queued_reqs.push_back(make_req(CMD_SINGLE, 4'hF, 32'd1, '0, '0, 5'd16));
		queued_reqs.push_back(make_req(CMD_TICK, '0, '0, '0, '0, '0));
		wait_drained();

		// Random phases with different idling profiles
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 84;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 84;
			end
			default: begin
				send_idle_pct = 20;
				recv_stall_pct = 20;
			end
			endcase
			for (n = 0; n < PHASE_REQS; n++)
				queued_reqs.push_back(random_req());
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/rptt_pkg.sv
hdl/rptt_ram.sv
hdl/rptt_timer.sv
hdl/rptt_outq.sv
hdl/relay_pulse_train_timer_core.sv
tb/tb_relay_pulse_train_timer_core.sv
